/* rtl/ets_pkg.sv */
package ets_pkg;

    localparam int KIND_W         = 4;
    localparam int LEN_W          = 4;
    localparam int TEXT_W         = 64;
    localparam int LEXEME_MAX_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    // token kinds
    localparam logic [KIND_W-1:0] TK_END      = 4'd0;
    localparam logic [KIND_W-1:0] TK_ADD      = 4'd1;
    localparam logic [KIND_W-1:0] TK_ASSIGN   = 4'd2;
    localparam logic [KIND_W-1:0] TK_LPAREN   = 4'd3;
    localparam logic [KIND_W-1:0] TK_RPAREN   = 4'd4;
    localparam logic [KIND_W-1:0] TK_SEMI     = 4'd5;
    localparam logic [KIND_W-1:0] TK_INTEGER  = 4'd6;
    localparam logic [KIND_W-1:0] TK_PRINT    = 4'd7;
    localparam logic [KIND_W-1:0] TK_VARIABLE = 4'd8;
    localparam logic [KIND_W-1:0] TK_UNKNOWN  = 4'd9;

    // punctuation bytes
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    // "print", first character in the lowest byte
    localparam logic [39:0] KW_PRINT = {8'h74, 8'h6E, 8'h69, 8'h72, 8'h70};
    localparam logic [LEN_W-1:0] KW_PRINT_LEN = 4'd5;

    // one queue entry: an optional flushed run token, then an optional
    // single-byte token (punctuation, unknown or end)
    typedef struct packed {
        logic              flush_vld;
        logic [KIND_W-1:0] flush_kind;
        logic [LEN_W-1:0]  flush_len;
        logic [TEXT_W-1:0] flush_text;
        logic              flush_trunc;
        logic              sec_vld;
        logic [KIND_W-1:0] sec_kind;
        logic [LEN_W-1:0]  sec_len;
        logic [7:0]        sec_byte;
    } t_entry;

endpackage

/* rtl/ets_front.sv */
module ets_front
    import ets_pkg::*;
#(
    parameter int LEXEME_MAX = LEXEME_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    input  logic       i_full,
    output logic       o_push,
    output t_entry     o_entry
);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_INT   = 2'd1,
        MODE_IDENT = 2'd2
    } t_mode;

    t_mode             r_mode, n_mode;
    logic [TEXT_W-1:0] r_text, n_text;
    logic [LEN_W-1:0]  r_count, n_count;
    logic              r_ovf, n_ovf;

    logic accept;
    logic running;
    logic is_digit, is_letter, is_space, cont, kw_match;
    logic [KIND_W-1:0] run_kind;

    assign accept    = i_valid && !i_full;
    assign is_digit  = (i_in_byte >= 8'h30) && (i_in_byte <= 8'h39);
    assign is_letter = ((i_in_byte >= 8'h61) && (i_in_byte <= 8'h7A)) ||
                       ((i_in_byte >= 8'h41) && (i_in_byte <= 8'h5A));
    assign is_space  = (i_in_byte == 8'h20) ||
                       ((i_in_byte >= 8'h09) && (i_in_byte <= 8'h0D));
    assign kw_match  = (r_count == KW_PRINT_LEN) && !r_ovf && (r_text[39:0] == KW_PRINT);

    always_comb begin
        running  = 1'b0;
        cont     = 1'b0;
        run_kind = TK_VARIABLE;
        unique case (r_mode)
            MODE_INT: begin
                running  = 1'b1;
                cont     = is_digit;
                run_kind = TK_INTEGER;
            end
            MODE_IDENT: begin
                running  = 1'b1;
                cont     = is_digit || is_letter;
                run_kind = kw_match ? TK_PRINT : TK_VARIABLE;
            end
            default: begin
                running = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_mode  = r_mode;
        n_text  = r_text;
        n_count = r_count;
        n_ovf   = r_ovf;
        o_entry = '0;
        o_entry.flush_kind  = run_kind;
        o_entry.flush_len   = r_count;
        o_entry.flush_text  = r_text;
        o_entry.flush_trunc = r_ovf;
        if (accept) begin
            if (i_end_of_input) begin
                o_entry.flush_vld = running;
                o_entry.sec_vld   = 1'b1;
                o_entry.sec_kind  = TK_END;
                n_mode  = MODE_IDLE;
                n_count = '0;
                n_ovf   = 1'b0;
            end else if (running && cont) begin
                // append, or mark overflow once the store is full
                if (r_count < LEN_W'(LEXEME_MAX)) begin
                    for (int i = 0; i < LEXEME_MAX; i++) begin
                        if (r_count == LEN_W'(i)) begin
                            n_text[8*i +: 8] = i_in_byte;
                        end
                    end
                    n_count = r_count + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
            end else begin
                o_entry.flush_vld = running;
                n_mode  = MODE_IDLE;
                n_count = '0;
                n_ovf   = 1'b0;
                if (is_space) begin
                    n_mode = MODE_IDLE;
                end else if (is_digit || is_letter) begin
                    n_mode  = is_digit ? MODE_INT : MODE_IDENT;
                    n_text  = {{(TEXT_W-8){1'b0}}, i_in_byte};
                    n_count = LEN_W'(1);
                end else begin
                    o_entry.sec_vld  = 1'b1;
                    o_entry.sec_len  = LEN_W'(1);
                    o_entry.sec_byte = i_in_byte;
                    unique case (i_in_byte) inside
                        CH_PLUS, CH_MINUS: o_entry.sec_kind = TK_ADD;
                        CH_EQUAL:          o_entry.sec_kind = TK_ASSIGN;
                        CH_LPAREN:         o_entry.sec_kind = TK_LPAREN;
                        CH_RPAREN:         o_entry.sec_kind = TK_RPAREN;
                        CH_SEMI:           o_entry.sec_kind = TK_SEMI;
                        default: begin
                            o_entry.sec_kind = TK_UNKNOWN;
                            o_entry.sec_len  = '0;
                            o_entry.sec_byte = '0;
                        end
                    endcase
                end
            end
        end
        o_push = accept && (o_entry.flush_vld || o_entry.sec_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
        r_text <= n_text;
    end

endmodule

/* rtl/ets_queue.sv */
module ets_queue
    import ets_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_head,
    output logic   o_empty,
    output logic   o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_slot [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_head  = r_slot[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

/* rtl/ets_back.sv */
module ets_back
    import ets_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_entry            i_head,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [KIND_W-1:0] o_token_kind,
    output logic [LEN_W-1:0]  o_lexeme_length,
    output logic [TEXT_W-1:0] o_lexeme_text,
    output logic              o_lexeme_truncated,
    output logic              o_last_of_run
);

    logic              r_valid;
    logic              r_phase;
    logic [KIND_W-1:0] r_kind;
    logic [LEN_W-1:0]  r_len;
    logic [TEXT_W-1:0] r_text;
    logic              r_trunc;
    logic              r_last;

    logic take, first;

    assign take  = (!r_valid || !i_stall) && !i_empty;
    assign first = i_head.flush_vld && !r_phase;
    assign o_pop = take && !(first && i_head.sec_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_phase <= first && i_head.sec_vld;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
        if (take) begin
            if (first) begin
                r_kind  <= i_head.flush_kind;
                r_len   <= i_head.flush_len;
                r_text  <= i_head.flush_text;
                r_trunc <= i_head.flush_trunc;
                r_last  <= !i_head.sec_vld;
            end else begin
                r_kind  <= i_head.sec_kind;
                r_len   <= i_head.sec_len;
                r_text  <= {{(TEXT_W-8){1'b0}}, i_head.sec_byte};
                r_trunc <= 1'b0;
                r_last  <= 1'b1;
            end
        end
    end

    assign o_valid            = r_valid;
    assign o_token_kind       = r_kind;
    assign o_lexeme_length    = r_len;
    assign o_lexeme_text      = r_text;
    assign o_lexeme_truncated = r_trunc;
    assign o_last_of_run      = r_last;

endmodule

/* rtl/expression_token_scanner_core.sv */
// Byte-serial token scanner: one source byte accepted per cycle unless the queue is full,
// one token sent per cycle unless the receiver stalls. Tokens pass through the entry queue
// and the output register before they can be taken; a two-token item yields both
// tokens from one entry. The entry queue between front and emitter absorbs these bursts, and
// the input stalls only while the queue is full (a pop in the same cycle does not free it).
// Reset (synchronous, active low) returns to no run in progress and empties the queue.
module expression_token_scanner_core
    import ets_pkg::*;
#(
    parameter int LEXEME_MAX  = LEXEME_MAX_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_in_byte,
    input  logic              i_end_of_input,
    // token output channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [KIND_W-1:0] o_token_kind,
    output logic [LEN_W-1:0]  o_lexeme_length,
    output logic [TEXT_W-1:0] o_lexeme_text,
    output logic              o_lexeme_truncated,
    output logic              o_last_of_run
);

    t_entry push_entry, head_entry;
    logic   push, pop, q_empty, q_full;

    // Hold the byte stream whenever the queue has no free slot.
    assign o_stall = q_full;

    // Front: classify bytes, track the current run, build token entries.
    ets_front #(
        .LEXEME_MAX (LEXEME_MAX)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .i_full         (q_full),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    // Decouple the front from output back-pressure.
    ets_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Back: expand each entry into one or two tokens through the output register.
    ets_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head             (head_entry),
        .i_empty            (q_empty),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_token_kind       (o_token_kind),
        .o_lexeme_length    (o_lexeme_length),
        .o_lexeme_text      (o_lexeme_text),
        .o_lexeme_truncated (o_lexeme_truncated),
        .o_last_of_run      (o_last_of_run)
    );

endmodule

/* tb/tb_expression_token_scanner_core.sv */
`timescale 1ns / 100ps

module tb_expression_token_scanner_core;
    import ets_pkg::*;

    localparam int LEX_MAX      = LEXEME_MAX_DEF;
    localparam int ITEM_TOTAL   = 1900;
    localparam int CALM_TAIL    = 300;   // last items run with no idling at all
    localparam int HOLD_AT      = 700;   // item count that triggers the long output hold
    localparam int PAUSE_AT     = 1200;  // item count that triggers the full drain pause
    localparam int HOLD_CYCLES  = 64;
    localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_CAP    = 40;

    // scanner run state, mirrored from the block's documented behavior
    typedef enum logic [1:0] {
        RUN_NONE,
        RUN_INTEGER,
        RUN_IDENT
    } t_run_kind;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  len;
        logic [TEXT_W-1:0] text;
        logic              trunc;
        logic              last;
    } t_token;

    // one directed item; a typed row carries its single token written out by hand
    typedef struct {
        logic [7:0] ch;
        logic       eoi;
        bit         typed;
        t_token     want;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [7:0]        i_in_byte;
    logic              i_end_of_input;
    logic              o_valid;
    logic              i_stall;
    logic [KIND_W-1:0] o_token_kind;
    logic [LEN_W-1:0]  o_lexeme_length;
    logic [TEXT_W-1:0] o_lexeme_text;
    logic              o_lexeme_truncated;
    logic              o_last_of_run;

    // predictor state
    t_run_kind  run_mode = RUN_NONE;
    logic [7:0] run_chars [LEX_MAX];
    int         run_len = 0;
    logic       run_ovf = 1'b0;

    t_token     step_tokens[$];      // tokens caused by the item just accepted
    t_token     expected_tokens[$];  // tokens still owed by the block, oldest first
    t_dir_row   dir_rows[$];

    int  items_sent   = 0;
    int  tokens_seen  = 0;
    int  errors       = 0;
    int  idle_pct     = 20;  // chance in percent that either side starts an idle burst
    int  quiet_cycles = 0;
    bit  hold_req     = 1'b0;

    expression_token_scanner_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_in_byte          (i_in_byte),
        .i_end_of_input     (i_end_of_input),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_token_kind       (o_token_kind),
        .o_lexeme_length    (o_lexeme_length),
        .o_lexeme_text      (o_lexeme_text),
        .o_lexeme_truncated (o_lexeme_truncated),
        .o_last_of_run      (o_last_of_run)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------

    function automatic bit is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic bit is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic t_token mk_token(input logic [KIND_W-1:0] kind,
                                        input logic [LEN_W-1:0] len,
                                        input logic [TEXT_W-1:0] text,
                                        input logic trunc);
        t_token t;
        t.kind  = kind;
        t.len   = len;
        t.text  = text;
        t.trunc = trunc;
        t.last  = 1'b0;
        return t;
    endfunction

    function automatic void start_run(input t_run_kind mode, input logic [7:0] b);
        run_mode     = mode;
        run_chars[0] = b;
        run_len      = 1;
        run_ovf      = 1'b0;
    endfunction

    // Emit the pending integer or identifier and go back to no run.
    function automatic void flush_run();
        logic [TEXT_W-1:0] text;
        logic [KIND_W-1:0] kind;
        text = '0;
        for (int i = 0; i < run_len; i++)
            text[8*i +: 8] = run_chars[i];
        // a truncated identifier can never be the keyword
        if (run_mode == RUN_INTEGER)
            kind = TK_INTEGER;
        else if (run_len == KW_PRINT_LEN && !run_ovf && text[39:0] == KW_PRINT)
            kind = TK_PRINT;
        else
            kind = TK_VARIABLE;
        step_tokens.push_back(mk_token(kind, LEN_W'(run_len), text, run_ovf));
        run_mode = RUN_NONE;
        run_len  = 0;
        run_ovf  = 1'b0;
    endfunction

    // Work out the tokens of one accepted item into step_tokens.
    function automatic void scan_predict(input logic [7:0] b, input logic eoi);
        logic [KIND_W-1:0] kind;
        t_token            tail;
        step_tokens.delete();
        if (eoi) begin
            // end mark: flush any run, then the end token; the byte is ignored
            if (run_mode != RUN_NONE)
                flush_run();
            step_tokens.push_back(mk_token(TK_END, '0, '0, 1'b0));
        end else begin
            if (run_mode != RUN_NONE) begin
                if (is_digit(b) || (run_mode == RUN_IDENT && is_letter(b))) begin
                    // extend the run; characters past the store are dropped
                    if (run_len < LEX_MAX) begin
                        run_chars[run_len] = b;
                        run_len++;
                    end else begin
                        run_ovf = 1'b1;
                    end
                    return;
                end
                flush_run();
            end
            if (is_digit(b)) begin
                start_run(RUN_INTEGER, b);
            end else if (is_letter(b)) begin
                start_run(RUN_IDENT, b);
            end else if (!(b == 8'h20 || (b >= 8'h09 && b <= 8'h0D))) begin
                case (b)
                    CH_PLUS, CH_MINUS: kind = TK_ADD;
                    CH_EQUAL:          kind = TK_ASSIGN;
                    CH_LPAREN:         kind = TK_LPAREN;
                    CH_RPAREN:         kind = TK_RPAREN;
                    CH_SEMI:           kind = TK_SEMI;
                    default:           kind = TK_UNKNOWN;
                endcase
                // unknown bytes carry an empty lexeme
                if (kind == TK_UNKNOWN)
                    step_tokens.push_back(mk_token(TK_UNKNOWN, '0, '0, 1'b0));
                else
                    step_tokens.push_back(mk_token(kind, LEN_W'(1), TEXT_W'(b), 1'b0));
            end
        end
        // flag the final token of this item
        if (step_tokens.size() != 0) begin
            tail = step_tokens[step_tokens.size()-1];
            tail.last = 1'b1;
            step_tokens[step_tokens.size()-1] = tail;
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("[%0t] token %0d: %s got %0h expected %0h",
                     $time, tokens_seen, what, got, want);
    endtask

    task automatic check_token();
        t_token want;
        if (expected_tokens.size() == 0) begin
            report_mismatch("token with none pending, kind", 64'(o_token_kind), '0);
        end else begin
            want = expected_tokens.pop_front();
            if (o_token_kind !== want.kind)
                report_mismatch("token_kind", 64'(o_token_kind), 64'(want.kind));
            if (o_lexeme_length !== want.len)
                report_mismatch("lexeme_length", 64'(o_lexeme_length), 64'(want.len));
            if (o_lexeme_text !== want.text)
                report_mismatch("lexeme_text", o_lexeme_text, want.text);
            if (o_lexeme_truncated !== want.trunc)
                report_mismatch("lexeme_truncated", 64'(o_lexeme_truncated),
                                64'(want.trunc));
            if (o_last_of_run !== want.last)
                report_mismatch("last_of_run", 64'(o_last_of_run), 64'(want.last));
        end
        tokens_seen++;
    endtask

    // Sample the token channel at the rising edge; the handshake fires when
    // valid is up and we are not stalling.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            check_token();
    end

    // Watchdog: end the run when neither channel has moved for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("expression_token_scanner_core regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Token receiver: random stall bursts, plus one long hold on request
    // ------------------------------------------------------------------

    initial begin
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                // hold off long enough for the block to fill and stall its input
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte sender
    // ------------------------------------------------------------------

    // Offer one item from a falling edge, hold it until accepted, then queue
    // its tokens. Return on the next falling edge.
    task automatic send_item(input logic [7:0] b, input logic eoi,
                             input bit typed, input t_token want);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_in_byte      <= b;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (o_stall);
        scan_predict(b, eoi);
        // typed rows stand in for the predictor's single token
        if (typed)
            expected_tokens.push_back(want);
        else
            foreach (step_tokens[i])
                expected_tokens.push_back(step_tokens[i]);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every owed token has come out.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (expected_tokens.size() != 0);
    endtask

    function automatic void add_row(input logic [7:0] ch, input logic eoi, input bit typed,
                                    input logic [KIND_W-1:0] kind,
                                    input logic [LEN_W-1:0] len,
                                    input logic [TEXT_W-1:0] text);
        t_dir_row row;
        row.ch        = ch;
        row.eoi       = eoi;
        row.typed     = typed;
        row.want      = mk_token(kind, len, text, 1'b0);
        row.want.last = 1'b1;
        dir_rows.push_back(row);
    endfunction

    // Add one untyped row per character of a word.
    function automatic void word_rows(input string word);
        for (int i = 0; i < word.len(); i++)
            add_row(word[i], 1'b0, 1'b0, TK_END, '0, '0);
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'(8'h61 + r) : 8'(8'h41 + r - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    // Send one random lexical chunk: mostly well-formed runs and operators,
    // with some stray bytes and end marks mixed in.
    task automatic send_chunk();
        string      word;
        int         pick;
        int         len;
        logic [7:0] ch;
        pick = $urandom_range(0, 99);
        // mostly short runs, now and then a longer one that may run past the lexeme store
        len  = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 11) : $urandom_range(1, 5);
        if (pick < 8) begin
            // the keyword and its near misses
            case ($urandom_range(0, 4))
                0:       word = "print";
                1:       word = "prin";
                2:       word = "prints";
                3:       word = "Print";
                default: word = "printprint";
            endcase
            for (int i = 0; i < word.len(); i++)
                send_item(word[i], 1'b0, 1'b0, '0);
        end else if (pick < 33) begin
            send_item(rand_letter(), 1'b0, 1'b0, '0);
            for (int i = 1; i < len; i++) begin
                ch = ($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter();
                send_item(ch, 1'b0, 1'b0, '0);
            end
        end else if (pick < 55) begin
            for (int i = 0; i < len; i++)
                send_item(rand_digit(), 1'b0, 1'b0, '0);
        end else if (pick < 75) begin
            case ($urandom_range(0, 5))
                0:       ch = CH_PLUS;
                1:       ch = CH_MINUS;
                2:       ch = CH_EQUAL;
                3:       ch = CH_LPAREN;
                4:       ch = CH_RPAREN;
                default: ch = CH_SEMI;
            endcase
            send_item(ch, 1'b0, 1'b0, '0);
        end else if (pick < 85) begin
            ch = ($urandom_range(0, 5) == 0) ? 8'h20 : 8'($urandom_range(9, 13));
            send_item(ch, 1'b0, 1'b0, '0);
        end else if (pick < 94) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        end else begin
            // end mark with a random byte that must be ignored
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
        end
    endtask

    initial begin
        int  next_shuffle;
        bit  hold_done;
        bit  paused;
        next_shuffle   = 150;
        hold_done      = 1'b0;
        paused         = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_in_byte      = '0;
        i_end_of_input = 1'b0;

        // Directed rows: every single-byte token, the byte extremes, whitespace,
        // an end mark with no run, the keyword closed by punctuation (two tokens
        // in one item) and an identifier past the store closed by an end mark.
        add_row(8'h00,     1'b0, 1'b1, TK_UNKNOWN, '0,        '0);
        add_row(8'hFF,     1'b0, 1'b1, TK_UNKNOWN, '0,        '0);
        add_row(CH_PLUS,   1'b0, 1'b1, TK_ADD,     LEN_W'(1), TEXT_W'(CH_PLUS));
        add_row(CH_MINUS,  1'b0, 1'b1, TK_ADD,     LEN_W'(1), TEXT_W'(CH_MINUS));
        add_row(CH_EQUAL,  1'b0, 1'b1, TK_ASSIGN,  LEN_W'(1), TEXT_W'(CH_EQUAL));
        add_row(CH_LPAREN, 1'b0, 1'b1, TK_LPAREN,  LEN_W'(1), TEXT_W'(CH_LPAREN));
        add_row(CH_RPAREN, 1'b0, 1'b1, TK_RPAREN,  LEN_W'(1), TEXT_W'(CH_RPAREN));
        add_row(CH_SEMI,   1'b0, 1'b1, TK_SEMI,    LEN_W'(1), TEXT_W'(CH_SEMI));
        add_row(8'h0D,     1'b0, 1'b0, TK_END,     '0,        '0);
        add_row(8'hAA,     1'b1, 1'b1, TK_END,     '0,        '0);
        word_rows("print;");
        word_rows("Az09xyzqw");
        add_row(8'h55,     1'b1, 1'b0, TK_END,     '0,        '0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].ch, dir_rows[i].eoi, dir_rows[i].typed, dir_rows[i].want);
        wait_drained();

        // random traffic with changing idle pressure
        while (items_sent < ITEM_TOTAL) begin
            if (items_sent >= next_shuffle) begin
                idle_pct     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 30);
                next_shuffle = next_shuffle + 150;
            end
            if (!hold_done && items_sent >= HOLD_AT) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!paused && items_sent >= PAUSE_AT) begin
                wait_drained();
                paused = 1'b1;
            end
            if (items_sent >= ITEM_TOTAL - CALM_TAIL)
                idle_pct = 0;
            send_chunk();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0)
            $display("expression_token_scanner_core regression: pass");
        else
            $display("expression_token_scanner_core regression: fail");
        $finish;
    end

endmodule
